FILE: hw/rtl/ecgr_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ecgr_pkg
// Shared types and constants of the ECG R-peak detector.
// ----------------------------------------------------------------------------
package ecgr_pkg;

    typedef enum logic [2:0] {
        S_IDLE,
        S_WALK_RD,
        S_WALK_CHK,
        S_AVG,
        S_AVG_WAIT,
        S_PCT,
        S_PCT_WAIT,
        S_FIN
    } t_state;

    typedef enum logic [2:0] {
        M_NONE,
        M_NOISE,
        M_BEAT,
        M_MISS,
        M_SB
    } t_mode;

    typedef enum logic {
        CFG_WEAK_PEAK_LEVEL = 1'b0,
        CFG_MISS_RUN_LIMIT  = 1'b1
    } t_cfg_idx;

    localparam int DIV_DW = 24;
    localparam int DIV_VW = 7;
    localparam int CFG_W  = 18;
    localparam int RR_W   = 16;

    // floor(x / 100) = (x * ceil(2^31 / 100)) >> 31, exact for x below 2^24
    localparam int                       PCT_SHIFT   = 31;
    localparam int                       PCT_RECIP_W = 25;
    localparam logic [PCT_RECIP_W-1:0]   PCT_RECIP   = 25'd21474837;

    localparam logic [RR_W-1:0]   RR_MAX           = 16'hFFFF;
    localparam logic [RR_W-1:0]   RR_HIGH_RESET    = 16'd300;
    localparam logic [CFG_W-1:0]  WEAK_RESET       = 18'd2000;
    localparam logic [3:0]        MISS_LIMIT_RESET = 4'd5;
    localparam logic [3:0]        MISS_RUN_MAX     = 4'd15;
    localparam int                UPPER_RESET      = 1000;
    localparam int                LOWER_RESET      = 500;

    // Limit index: 0 low (92 %), 1 high (116 %), 2 miss (166 %)
    localparam logic [1:0] LIM_LOW  = 2'd0;
    localparam logic [1:0] LIM_HIGH = 2'd1;
    localparam logic [1:0] LIM_MISS = 2'd2;

    typedef struct packed {
        logic              start;
        logic [DIV_DW-1:0] dividend;
        logic [DIV_VW-1:0] divisor;
    } t_div_req;

    function automatic logic [7:0] pct_of(input logic [1:0] idx);
        logic [7:0] v;
        unique case (idx)
            LIM_LOW:  v = 8'd92;
            LIM_HIGH: v = 8'd116;
            default:  v = 8'd166;
        endcase
        return v;
    endfunction

endpackage

FILE: hw/rtl/ecgr_div.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ecgr_div
// Shared restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module ecgr_div (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  ecgr_pkg::t_div_req         i_req,
    output logic                       o_done,
    output logic [ecgr_pkg::DIV_DW-1:0] o_quot
);
    import ecgr_pkg::*;

    localparam int CW = $clog2(DIV_DW + 1);

    logic [DIV_VW-1:0] r_rem;
    logic [DIV_DW-1:0] r_quo;
    logic [DIV_VW-1:0] r_dvs;
    logic [CW-1:0]     r_cnt;
    logic              r_done;
    logic [DIV_VW:0]   rem_sh;
    logic              fits;

    assign rem_sh = {r_rem, r_quo[DIV_DW-1]};
    assign fits   = rem_sh >= {1'b0, r_dvs};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt  <= '0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_cnt <= CW'(DIV_DW);
            end else if (r_cnt != '0) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == CW'(1)) begin
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_rem <= '0;
            r_quo <= i_req.dividend;
            r_dvs <= i_req.divisor;
        end else if (r_cnt != '0) begin
            // Subtract when the shifted remainder covers the divisor
            r_rem <= fits ? DIV_VW'(rem_sh - {1'b0, r_dvs}) : rem_sh[DIV_VW-1:0];
            r_quo <= {r_quo[DIV_DW-2:0], fits};
        end
    end

    assign o_done = r_done;
    assign o_quot = r_quo;

endmodule

FILE: hw/rtl/ecgr_peak_mem.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ecgr_peak_mem
// Peak history: ring memory with fill count, read by age offset.
// ----------------------------------------------------------------------------
module ecgr_peak_mem #(
    parameter int DEPTH = 128,
    parameter int DW    = 18
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_wr_en,
    input  logic [DW-1:0]            i_wr_data,
    input  logic                     i_rd_en,
    input  logic [$clog2(DEPTH)-1:0] i_rd_off,
    output logic [DW-1:0]            o_rd_data
);
    localparam int AW = $clog2(DEPTH);

    logic [DW-1:0] mem [DEPTH];
    logic [AW-1:0] r_wptr;
    logic [AW:0]   r_count;
    logic [DW-1:0] r_data;
    logic          r_hit;
    logic [AW:0]   addr_raw;
    logic [AW-1:0] rd_addr;

    // Newest entry sits at wptr-1; offset counts toward older entries
    assign addr_raw = {1'b0, r_wptr} + (AW+1)'(DEPTH - 1) - {1'b0, i_rd_off};
    assign rd_addr  = (addr_raw >= (AW+1)'(DEPTH)) ?
                      AW'(addr_raw - (AW+1)'(DEPTH)) : addr_raw[AW-1:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_count <= '0;
        end else if (i_wr_en) begin
            r_wptr <= (r_wptr == AW'(DEPTH - 1)) ? '0 : r_wptr + 1'b1;
            if (r_count != (AW+1)'(DEPTH)) begin
                r_count <= r_count + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            mem[r_wptr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_data <= mem[rd_addr];
            r_hit  <= {1'b0, i_rd_off} < r_count;
        end
    end

    // Entries never filled read as zero
    assign o_rd_data = r_hit ? r_data : '0;

endmodule

FILE: hw/rtl/ecg_r_peak_detector.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ecg_r_peak_detector
// QRS (R-peak) detector on filtered, integrated ECG samples.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel: i_valid / o_stall with i_sample. A transaction is taken
//   when i_valid is high and o_stall is low. Output channel: o_valid /
//   i_stall with one result transaction per sample.
//   Configuration: i_cfg_we, i_cfg_idx, i_cfg_data; write only while idle.
//   Processing (one sample in flight at a time):
//     - no peak, noise peak or rejected peak: straight to the result state;
//     - accepted beat: the shared bit-serial divider forms the RR average,
//       then each percent limit is computed in turn;
//     - searchback: as a beat, after a walk of the peak history with a
//       registered memory read per entry, up to PEAK_DEPTH entries.
//   The next sample is taken once the previous result has left the output
//   register. When the receiver stalls, the result holds and o_stall stays
//   high. Reset (synchronous, active low) restores all state kept across
//   samples; the peak history is emptied by its fill count, not cleared.
// ----------------------------------------------------------------------------
module ecg_r_peak_detector #(
    parameter int PEAK_DEPTH  = 128,
    parameter int RR_DEPTH    = 8,
    parameter int SAMPLE_BITS = 18
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_valid,
    output logic                   o_stall,
    input  logic [SAMPLE_BITS-1:0] i_sample,
    output logic                   o_valid,
    input  logic                   i_stall,
    output logic                   o_r_peak_found,
    output logic                   o_by_searchback,
    output logic [SAMPLE_BITS-1:0] o_peak_value,
    output logic [15:0]            o_rr_interval,
    output logic                   o_low_peak_warning,
    output logic                   o_missed_warning,
    output logic [SAMPLE_BITS-1:0] o_level_threshold,
    input  logic                   i_cfg_we,
    input  logic                   i_cfg_idx,
    input  logic [17:0]            i_cfg_data
);
    import ecgr_pkg::*;

    localparam int SB   = SAMPLE_BITS;
    localparam int AW   = $clog2(PEAK_DEPTH);
    localparam int FW   = $clog2(RR_DEPTH + 1);
    localparam int SW   = RR_W + FW;
    localparam int PM_W = DIV_DW + PCT_RECIP_W;
    localparam int PQ_W = PM_W - PCT_SHIFT;

    // Configuration registers
    logic [CFG_W-1:0] r_weak;
    logic [3:0]       r_miss_limit;

    // Detector state
    t_state           r_state, n_state;
    t_mode            r_mode;
    logic [SB-1:0]    r_w1, r_w2;
    logic             r_rise;
    logic [RR_W-1:0]  r_rr_store [RR_DEPTH];
    logic [SW-1:0]    r_rr_sum;
    logic [FW-1:0]    r_rr_filled;
    logic [RR_W-1:0]  r_rr_cnt;
    logic [RR_W-1:0]  r_low, r_high, r_miss_lim;
    logic [SB-1:0]    r_sig, r_noise, r_upper, r_lower;
    logic [3:0]       r_miss_run;
    logic [SB-1:0]    r_peak;
    logic             r_missw;
    logic [RR_W-1:0]  r_rr_out;
    logic [AW-1:0]    r_off;
    logic [RR_W-1:0]  r_avg;
    logic [1:0]       r_lim_idx;
    logic [DIV_DW-1:0] r_prod;

    // Output register
    logic             r_out_valid;
    logic             r_o_found, r_o_sb, r_o_loww, r_o_missw;
    logic [SB-1:0]    r_o_peak, r_o_thr;
    logic [RR_W-1:0]  r_o_rr;

    // Sequencer controls
    t_div_req         div_req;
    logic             div_done;
    logic [DIV_DW-1:0] div_quot;
    logic             mem_rd;
    logic             accept;

    // Combinational helpers
    logic             rise_now, is_peak, in_win, walk_end, found;
    logic [RR_W-1:0]  cnt_inc, cnt_dec;
    logic [3:0]       miss_inc;
    logic [SB+2:0]    noise_acc, sig_acc;
    logic [SB+1:0]    thr_acc, sb_acc;
    logic [SB-1:0]    thr_up;
    logic [SW-1:0]    sum_push;
    logic [SB-1:0]    mem_rd_data;
    logic [DIV_DW-1:0] pct_prod;
    logic [PM_W-1:0]  pct_mul;
    logic [PQ_W-1:0]  pct_quot;
    logic [RR_W-1:0]  lim_sat;
    logic [RR_W-1:0]  avg_sat;

    assign accept  = i_valid && !o_stall;
    assign o_stall = (r_state != S_IDLE) || r_out_valid;

    // Three-sample window: w0 = r_w1, w1 = r_w2, w2 = incoming sample
    assign rise_now = r_rise || (r_w2 > r_w1);
    assign is_peak  = rise_now && (r_w1 <= r_w2) && (r_w2 > i_sample);
    assign in_win   = (r_rr_cnt <= r_high) && (r_rr_cnt >= r_low);
    assign cnt_inc  = (r_rr_cnt == RR_MAX) ? r_rr_cnt : r_rr_cnt + 1'b1;
    assign cnt_dec  = (r_rr_cnt == '0) ? r_rr_cnt : r_rr_cnt - 1'b1;
    assign miss_inc = (r_miss_run == MISS_RUN_MAX) ? r_miss_run : r_miss_run + 1'b1;

    // level' = (peak + 7*level) / 8
    assign noise_acc = (SB+3)'(r_w2) + ((SB+3)'(r_noise) << 3) - (SB+3)'(r_noise);
    assign sig_acc   = (SB+3)'(r_w2) + ((SB+3)'(r_sig) << 3) - (SB+3)'(r_sig);
    // upper = (3*noise + signal) / 4, from current registers
    assign thr_acc   = ((SB+2)'(r_noise) << 1) + (SB+2)'(r_noise) + (SB+2)'(r_sig);
    assign thr_up    = thr_acc[SB+1:2];
    // searchback signal' = (peak + 3*signal) / 4
    assign sb_acc    = (SB+2)'(r_peak) + ((SB+2)'(r_sig) << 1) + (SB+2)'(r_sig);

    // Running RR sum: drop the oldest entry, add the current counter
    assign sum_push = r_rr_sum - SW'(r_rr_store[0]) + SW'(r_rr_cnt);

    assign walk_end = (mem_rd_data > r_lower) || (r_off == AW'(PEAK_DEPTH - 1));
    assign avg_sat  = (div_quot[DIV_DW-1:RR_W] != '0) ? RR_MAX : div_quot[RR_W-1:0];

    // Percent limit: product registered, then divided by 100 through a
    // reciprocal multiply in the following cycle
    assign pct_prod = DIV_DW'(r_avg) * DIV_DW'(pct_of(r_lim_idx));
    assign pct_mul  = PM_W'(r_prod) * PM_W'(PCT_RECIP);
    assign pct_quot = pct_mul[PM_W-1:PCT_SHIFT];
    assign lim_sat  = (pct_quot[PQ_W-1:RR_W] != '0) ? RR_MAX : pct_quot[RR_W-1:0];
    assign found    = (r_mode == M_BEAT) || (r_mode == M_SB);

    ecgr_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (div_req),
        .o_done  (div_done),
        .o_quot  (div_quot)
    );

    ecgr_peak_mem #(
        .DEPTH (PEAK_DEPTH),
        .DW    (SB)
    ) u_peak_mem (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_wr_en   (accept && is_peak),
        .i_wr_data (r_w2),
        .i_rd_en   (mem_rd),
        .i_rd_off  (r_off),
        .o_rd_data (mem_rd_data)
    );

    // Next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_state = S_FIN;
                    if (is_peak && (r_w2 > r_upper)) begin
                        if (in_win) begin
                            n_state = S_AVG;
                        end else if (r_rr_cnt > r_miss_lim) begin
                            n_state = S_WALK_RD;
                        end
                    end
                end
            end
            S_WALK_RD:  n_state = S_WALK_CHK;
            S_WALK_CHK: n_state = walk_end ? S_AVG : S_WALK_RD;
            S_AVG:      n_state = S_AVG_WAIT;
            S_AVG_WAIT: n_state = div_done ? S_PCT : S_AVG_WAIT;
            S_PCT:      n_state = S_PCT_WAIT;
            S_PCT_WAIT: n_state = (r_lim_idx == LIM_MISS) ? S_FIN : S_PCT;
            S_FIN:      n_state = S_IDLE;
            default:    n_state = S_IDLE;
        endcase
    end

    // Sequencer outputs
    always_comb begin
        div_req = '0;
        mem_rd  = 1'b0;
        unique case (r_state)
            S_WALK_RD: mem_rd = 1'b1;
            S_AVG: begin
                div_req.start    = 1'b1;
                div_req.dividend = DIV_DW'(r_rr_sum);
                div_req.divisor  = (r_mode == M_SB) ? DIV_VW'(RR_DEPTH)
                                                    : DIV_VW'(r_rr_filled);
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_weak       <= WEAK_RESET;
            r_miss_limit <= MISS_LIMIT_RESET;
        end else if (i_cfg_we) begin
            if (i_cfg_idx == CFG_WEAK_PEAK_LEVEL) begin
                r_weak <= i_cfg_data;
            end
            if (i_cfg_idx == CFG_MISS_RUN_LIMIT) begin
                r_miss_limit <= i_cfg_data[3:0];
            end
        end
    end

    // Detector datapath
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode      <= M_NONE;
            r_w1        <= '0;
            r_w2        <= '0;
            r_rise      <= 1'b0;
            for (int k = 0; k < RR_DEPTH; k++) begin
                r_rr_store[k] <= '0;
            end
            r_rr_sum    <= '0;
            r_rr_filled <= '0;
            r_rr_cnt    <= '0;
            r_low       <= '0;
            r_high      <= RR_HIGH_RESET;
            r_miss_lim  <= '0;
            r_sig       <= '0;
            r_noise     <= '0;
            r_upper     <= SB'(UPPER_RESET);
            r_lower     <= SB'(LOWER_RESET);
            r_miss_run  <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (o_valid && !i_stall) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (accept) begin
                        r_w1     <= r_w2;
                        r_w2     <= i_sample;
                        r_rise   <= rise_now && !is_peak;
                        r_peak   <= r_w2;
                        r_missw  <= 1'b0;
                        r_rr_cnt <= cnt_inc;
                        r_rr_out <= cnt_inc;
                        r_mode   <= M_NONE;
                        if (is_peak) begin
                            if (r_w2 <= r_upper) begin
                                r_mode  <= M_NOISE;
                                r_noise <= noise_acc[SB+2:3];
                            end else if (in_win) begin
                                // Accepted beat: push the interval, average later
                                r_mode   <= M_BEAT;
                                r_sig    <= sig_acc[SB+2:3];
                                r_rr_out <= r_rr_cnt;
                                r_rr_sum <= sum_push;
                                for (int k = 0; k < RR_DEPTH - 1; k++) begin
                                    r_rr_store[k] <= r_rr_store[k+1];
                                end
                                r_rr_store[RR_DEPTH-1] <= r_rr_cnt;
                                if (r_rr_filled != FW'(RR_DEPTH)) begin
                                    r_rr_filled <= r_rr_filled + 1'b1;
                                end
                            end else begin
                                r_mode     <= M_MISS;
                                r_miss_run <= miss_inc;
                                r_missw    <= miss_inc >= r_miss_limit;
                                if (r_rr_cnt > r_miss_lim) begin
                                    // Hold the counter; the walk lowers it
                                    r_mode   <= M_SB;
                                    r_rr_cnt <= r_rr_cnt;
                                    r_off    <= '0;
                                end
                            end
                        end
                    end
                end
                S_WALK_CHK: begin
                    if (walk_end) begin
                        r_peak   <= mem_rd_data;
                        r_rr_out <= r_rr_cnt;
                        r_rr_sum <= sum_push;
                        for (int k = 0; k < RR_DEPTH - 1; k++) begin
                            r_rr_store[k] <= r_rr_store[k+1];
                        end
                        r_rr_store[RR_DEPTH-1] <= r_rr_cnt;
                    end else begin
                        r_off    <= r_off + 1'b1;
                        r_rr_cnt <= cnt_dec;
                    end
                end
                S_AVG: begin
                    r_lim_idx <= LIM_LOW;
                end
                S_AVG_WAIT: begin
                    if (div_done) begin
                        r_avg <= avg_sat;
                    end
                end
                S_PCT: begin
                    r_prod <= pct_prod;
                end
                S_PCT_WAIT: begin
                    unique case (r_lim_idx)
                        LIM_LOW:  r_low      <= lim_sat;
                        LIM_HIGH: r_high     <= lim_sat;
                        default:  r_miss_lim <= lim_sat;
                    endcase
                    r_lim_idx <= r_lim_idx + 1'b1;
                end
                S_FIN: begin
                    // Thresholds use the signal before a searchback update
                    if (r_mode == M_NOISE || found) begin
                        r_upper <= thr_up;
                        r_lower <= thr_up >> 1;
                    end
                    if (r_mode == M_SB) begin
                        r_sig <= sb_acc[SB+1:2];
                    end
                    if (found) begin
                        r_rr_cnt   <= RR_W'(1);
                        r_miss_run <= '0;
                    end
                    r_out_valid <= 1'b1;
                    r_o_found   <= found;
                    r_o_sb      <= (r_mode == M_SB);
                    r_o_peak    <= found ? r_peak : '0;
                    r_o_rr      <= found ? r_rr_out : r_rr_cnt;
                    r_o_loww    <= found && ((33)'(r_peak) < (33)'(r_weak));
                    r_o_missw   <= r_missw;
                    r_o_thr     <= (r_mode == M_NOISE || found) ? thr_up : r_upper;
                end
                default: ;
            endcase
        end
    end

    assign o_valid            = r_out_valid;
    assign o_r_peak_found     = r_o_found;
    assign o_by_searchback    = r_o_sb;
    assign o_peak_value       = r_o_peak;
    assign o_rr_interval      = r_o_rr;
    assign o_low_peak_warning = r_o_loww;
    assign o_missed_warning   = r_o_missw;
    assign o_level_threshold  = r_o_thr;

endmodule

FILE: dv/ecgr_beat_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ecgr_beat_checker
// Watches both channels of the R-peak detector and checks every result.
// Keeps its own copy of the detection state, computes the expected result
// for each accepted sample and compares it, field by field, with the
// results the block hands out, oldest first.
// ----------------------------------------------------------------------------
module ecgr_beat_checker
    import ecgr_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    input  logic        o_stall,
    input  logic [17:0] i_sample,
    input  logic        o_valid,
    input  logic        i_stall,
    input  logic        o_r_peak_found,
    input  logic        o_by_searchback,
    input  logic [17:0] o_peak_value,
    input  logic [15:0] o_rr_interval,
    input  logic        o_low_peak_warning,
    input  logic        o_missed_warning,
    input  logic [17:0] o_level_threshold,
    input  logic        i_cfg_we,
    input  logic        i_cfg_idx,
    input  logic [17:0] i_cfg_data,
    output int          o_errors,
    output int          o_pending
);

    localparam int HIST_N = 128;
    localparam int RRH_N  = 8;

    typedef struct {
        logic        found;
        logic        sb;
        logic [17:0] pval;
        logic [15:0] rr;
        logic        loww;
        logic        missw;
        logic [17:0] thr;
    } t_beat_result;

    t_beat_result beat_q[$];

    logic [17:0] win [3];
    logic        rising;
    logic [17:0] peak_hist [HIST_N];
    int          rr_hist [RRH_N];
    int          rr_fill;
    int          rr_count;
    int          lim_lo, lim_hi, lim_miss;
    int          sig_lvl, noise_lvl, thr_hi, thr_lo;
    int          miss_cnt;
    int          weak_lvl, miss_lim;
    int          errors;

    assign o_errors  = errors;
    assign o_pending = beat_q.size();

    function automatic int pct_sat(input int avg, input int pct);
        int v;
        v = avg * pct / 100;
        return (v > 65535) ? 65535 : v;
    endfunction

    task automatic clear_state();
        weak_lvl = 2000;
        miss_lim = 5;
        foreach (win[k]) win[k] = '0;
        rising = 1'b0;
        foreach (peak_hist[k]) peak_hist[k] = '0;
        foreach (rr_hist[k]) rr_hist[k] = 0;
        rr_fill  = 0;
        rr_count = 0;
        lim_lo   = 0;
        lim_hi   = 300;
        lim_miss = 0;
        sig_lvl  = 0;
        noise_lvl = 0;
        thr_hi   = 1000;
        thr_lo   = 500;
        miss_cnt = 0;
        beat_q.delete();
    endtask

    task automatic retune_thresholds();
        thr_hi = (3 * noise_lvl + sig_lvl) / 4;
        thr_lo = thr_hi / 2;
    endtask

    // Shift the interval into the RR history and return the history sum.
    function automatic int shift_rr(input int v);
        int sum;
        sum = 0;
        for (int k = 0; k < RRH_N - 1; k++) rr_hist[k] = rr_hist[k + 1];
        rr_hist[RRH_N - 1] = v;
        foreach (rr_hist[k]) sum += rr_hist[k];
        return sum;
    endfunction

    task automatic set_rr_limits(input int avg);
        lim_lo   = pct_sat(avg, 92);
        lim_hi   = pct_sat(avg, 116);
        lim_miss = pct_sat(avg, 166);
    endtask

    task automatic predict_beat(input logic [17:0] s);
        t_beat_result r;
        logic [17:0]  p;
        int           pos;
        int           sum;
        r = '{default: '0};
        win[0] = win[1];
        win[1] = win[2];
        win[2] = s;
        if (!rising && win[1] > win[0]) rising = 1'b1;
        if (rising && win[0] <= win[1] && win[1] > win[2]) begin
            p = win[1];
            rising = 1'b0;
            for (int k = 0; k < HIST_N - 1; k++) peak_hist[k] = peak_hist[k + 1];
            peak_hist[HIST_N - 1] = p;
            if (int'(p) > thr_hi) begin
                if (rr_count <= lim_hi && rr_count >= lim_lo) begin
                    // regular beat inside the RR window
                    sum = shift_rr(rr_count);
                    if (rr_fill < RRH_N) rr_fill++;
                    set_rr_limits(sum / rr_fill);
                    sig_lvl = (int'(p) + 7 * sig_lvl) / 8;
                    retune_thresholds();
                    r.found = 1'b1;
                    r.pval  = p;
                    r.rr    = rr_count[15:0];
                    miss_cnt = 0;
                    rr_count = 0;
                end else begin
                    if (miss_cnt < 15) miss_cnt++;
                    if (miss_cnt >= miss_lim) r.missw = 1'b1;
                    if (rr_count > lim_miss) begin
                        // walk back to the newest peak above the lower threshold
                        pos = HIST_N - 1;
                        while (pos > 0 && int'(peak_hist[pos]) <= thr_lo) begin
                            pos--;
                            if (rr_count > 0) rr_count--;
                        end
                        r.pval = peak_hist[pos];
                        sum = shift_rr(rr_count);
                        set_rr_limits(sum / RRH_N);
                        retune_thresholds();
                        sig_lvl = (int'(r.pval) + 3 * sig_lvl) / 4;
                        r.found = 1'b1;
                        r.sb    = 1'b1;
                        r.rr    = rr_count[15:0];
                        miss_cnt = 0;
                        rr_count = 0;
                    end
                end
                if (r.found && int'(r.pval) < weak_lvl) r.loww = 1'b1;
            end else begin
                noise_lvl = (int'(p) + 7 * noise_lvl) / 8;
                retune_thresholds();
            end
        end
        if (rr_count < 65535) rr_count++;
        if (!r.found) r.rr = rr_count[15:0];
        r.thr = thr_hi[17:0];
        beat_q.push_back(r);
    endtask

    task automatic report(input string what, input int got, input int want);
        $display("%0t ns: mismatch on %s: got %0d, expected %0d", $time, what, got, want);
        errors++;
    endtask

    task automatic check_result();
        t_beat_result e;
        if (beat_q.size() == 0) begin
            report("result with nothing pending", 1, 0);
            return;
        end
        e = beat_q.pop_front();
        if (o_r_peak_found !== e.found)     report("r_peak_found", o_r_peak_found, e.found);
        if (o_by_searchback !== e.sb)       report("by_searchback", o_by_searchback, e.sb);
        if (o_peak_value !== e.pval)        report("peak_value", o_peak_value, e.pval);
        if (o_rr_interval !== e.rr)         report("rr_interval", o_rr_interval, e.rr);
        if (o_low_peak_warning !== e.loww)  report("low_peak_warning", o_low_peak_warning,
                                                   e.loww);
        if (o_missed_warning !== e.missw)   report("missed_warning", o_missed_warning, e.missw);
        if (o_level_threshold !== e.thr)    report("level_threshold", o_level_threshold, e.thr);
    endtask

    initial begin
        errors = 0;
        clear_state();
    end

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            clear_state();
        end else begin
            if (i_cfg_we) begin
                if (i_cfg_idx == CFG_WEAK_PEAK_LEVEL) weak_lvl = int'(i_cfg_data);
                else miss_lim = int'(i_cfg_data[3:0]);
            end
            if (o_valid && !i_stall) check_result();
            if (i_valid && !o_stall) predict_beat(i_sample);
        end
    end

endmodule

FILE: dv/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Stimulus and verdict for the ECG R-peak detector.
// Drives synthetic ECG traces (regular beats, skipped and weak beats, noise,
// a long flat stretch) through several register settings and idle patterns;
// a checker beside the block predicts and compares every result.
// ----------------------------------------------------------------------------
module tb;
    import ecgr_pkg::*;

    localparam int WATCHDOG_LIMIT = 8000;
    localparam int DRAIN_CYCLES   = 600;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_valid;
    logic        o_stall;
    logic [17:0] i_sample;
    logic        o_valid;
    logic        i_stall;
    logic        o_r_peak_found;
    logic        o_by_searchback;
    logic [17:0] o_peak_value;
    logic [15:0] o_rr_interval;
    logic        o_low_peak_warning;
    logic        o_missed_warning;
    logic [17:0] o_level_threshold;
    logic        i_cfg_we;
    logic        i_cfg_idx;
    logic [17:0] i_cfg_data;

    int errors;
    int pending;
    int idle_pct;
    int stall_pct;
    int holdoff_req;
    int holdoff_left;
    int quiet_cycles;
    int samples_sent;

    ecg_r_peak_detector u_dut (.*);

    ecgr_beat_checker u_chk (
        .i_clk, .i_rst_n, .i_valid, .o_stall, .i_sample, .o_valid, .i_stall,
        .o_r_peak_found, .o_by_searchback, .o_peak_value, .o_rr_interval,
        .o_low_peak_warning, .o_missed_warning, .o_level_threshold,
        .i_cfg_we, .i_cfg_idx, .i_cfg_data,
        .o_errors(errors), .o_pending(pending)
    );

    // 8 ns clock
    initial i_clk = 1'b0;
    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    // Receiver: random stall, or a long hold-off when one is requested.
    always @(posedge i_clk) begin
        if (holdoff_req > 0) begin
            holdoff_left = holdoff_req;
            holdoff_req  = 0;
        end
        if (holdoff_left > 0) begin
            holdoff_left--;
            i_stall <= 1'b1;
        end else begin
            i_stall <= ($urandom_range(99) < stall_pct);
        end
    end

    // Watchdog: abort when neither channel moves for too long.
    always @(posedge i_clk) begin
        if ((i_valid && !o_stall) || (o_valid && !i_stall) || !i_rst_n) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("Simulation FAILED");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // Offer one sample and hold it until the transaction is taken.
    task automatic send_sample(input logic [17:0] s);
        while ($urandom_range(99) < idle_pct) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid  <= 1'b1;
        i_sample <= s;
        do @(negedge i_clk); while (o_stall);
        @(posedge i_clk);
        samples_sent++;
    endtask

    // Drop valid and wait until every expected result has come out.
    task automatic drain();
        i_valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(input t_cfg_idx idx, input logic [17:0] data);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= data;
        @(posedge i_clk);
        i_cfg_we   <= 1'b0;
    endtask

    // One beat: quiet baseline with small bumps, then a sharp pulse.
    task automatic emit_beat(input int period, input int amp);
        int gap;
        gap = period + $urandom_range(2) - 1 - 5;
        for (int k = 0; k < gap; k++) send_sample(18'($urandom_range(40)));
        send_sample(18'(amp / 4));
        send_sample(18'(amp / 2));
        send_sample(18'(amp));
        send_sample(18'(amp / 3));
        send_sample(18'($urandom_range(40)));
    endtask

    // Mostly regular beat trains, with skipped and weak beats and noise bursts.
    task automatic beat_phase(input int n_samples);
        int stop_at;
        int period;
        int amp;
        int pick;
        stop_at = samples_sent + n_samples;
        period  = $urandom_range(20, 90);
        while (samples_sent < stop_at) begin
            pick = $urandom_range(99);
            amp  = $urandom_range(1500, 262143);
            if (pick < 70) begin
                emit_beat(period, amp);
            end else if (pick < 82) begin
                // skipped beat: a weak bump, then a long gap
                emit_beat(period, amp / 3);
                emit_beat(period * 2, amp);
            end else if (pick < 88) begin
                emit_beat(period, $urandom_range(1001, 3000));
            end else if (pick < 94) begin
                repeat ($urandom_range(4, 20)) send_sample(18'($urandom));
            end else begin
                period = $urandom_range(20, 90);
                emit_beat(period, amp);
            end
        end
    endtask

    initial begin
        i_rst_n      = 1'b0;
        i_valid      = 1'b0;
        i_sample     = '0;
        i_stall      = 1'b0;
        i_cfg_we     = 1'b0;
        i_cfg_idx    = CFG_WEAK_PEAK_LEVEL;
        i_cfg_data   = '0;
        idle_pct     = 0;
        stall_pct    = 0;
        holdoff_req  = 0;
        holdoff_left = 0;
        quiet_cycles = 0;
        samples_sent = 0;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: field extremes, bit patterns, a first beat, a weak beat,
        // equal neighbors at a peak and a noise peak.
        send_sample(18'd0);
        send_sample(18'h3FFFF);
        send_sample(18'd0);
        send_sample(18'h15555);
        send_sample(18'h2AAAA);
        send_sample(18'd0);
        send_sample(18'd800);
        send_sample(18'd800);
        send_sample(18'd100);
        for (int k = 0; k < 6; k++) send_sample(18'd0);
        send_sample(18'd1200);
        send_sample(18'd1500);
        send_sample(18'd0);
        send_sample(18'd0);
        send_sample(18'd300);
        send_sample(18'd20);
        send_sample(18'h3FFFF);
        send_sample(18'h3FFFE);
        send_sample(18'd0);
        drain();

        // Flat stretch, then a pulse that falls far outside the RR interval.
        for (int k = 0; k < 300; k++) send_sample(18'd0);
        send_sample(18'd150000);
        send_sample(18'd0);
        send_sample(18'd0);
        drain();

        // Phase 1: no idling, extreme register values, one long hold-off.
        write_reg(CFG_WEAK_PEAK_LEVEL, 18'h3FFFF);
        write_reg(CFG_MISS_RUN_LIMIT, 18'd1);
        idle_pct  = 0;
        stall_pct = 0;
        holdoff_req = 400;
        beat_phase(150);
        // pause the sender until everything is out, then go on
        i_valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        beat_phase(150);
        drain();

        // Phase 2: sender idles.
        write_reg(CFG_WEAK_PEAK_LEVEL, 18'd0);
        write_reg(CFG_MISS_RUN_LIMIT, 18'd15);
        idle_pct  = 48;
        stall_pct = 0;
        beat_phase(300);
        drain();

        // Phase 3: receiver stalls.
        write_reg(CFG_WEAK_PEAK_LEVEL, 18'($urandom_range(1000, 60000)));
        write_reg(CFG_MISS_RUN_LIMIT, 18'($urandom_range(1, 15)));
        idle_pct  = 0;
        stall_pct = 48;
        beat_phase(300);
        drain();

        // Phase 4: both sides idle now and then, default registers.
        write_reg(CFG_WEAK_PEAK_LEVEL, WEAK_RESET);
        write_reg(CFG_MISS_RUN_LIMIT, 18'(MISS_LIMIT_RESET));
        idle_pct  = 12;
        stall_pct = 12;
        beat_phase(300);
        drain();

        if (errors == 0 && pending == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule

FILE: sim.f
hw/rtl/ecgr_pkg.sv
hw/rtl/ecgr_div.sv
hw/rtl/ecgr_peak_mem.sv
hw/rtl/ecg_r_peak_detector.sv
dv/ecgr_beat_checker.sv
dv/tb.sv
